// ===== hdl/scsi_cdb_pkg.sv =====
package scsi_cdb_pkg;

    // command opcodes
    localparam logic [7:0] OP_TEST_UNIT_READY  = 8'h00;
    localparam logic [7:0] OP_READ_6           = 8'h08;
    localparam logic [7:0] OP_WRITE_6          = 8'h0A;
    localparam logic [7:0] OP_INQUIRY          = 8'h12;
    localparam logic [7:0] OP_READ_CAPACITY_10 = 8'h25;
    localparam logic [7:0] OP_READ_10          = 8'h28;
    localparam logic [7:0] OP_WRITE_10         = 8'h2A;
    localparam logic [7:0] OP_VERIFY_10        = 8'h2F;
    localparam logic [7:0] OP_SYNC_CACHE_10    = 8'h35;
    localparam logic [7:0] OP_MODE_SENSE_10    = 8'h5A;
    localparam logic [7:0] OP_READ_CAPACITY_16 = 8'h9E;
    localparam logic [7:0] OP_REPORT_LUNS      = 8'hA0;

    // actions
    localparam logic [2:0] ACT_COMPLETE = 3'd0;
    localparam logic [2:0] ACT_READ     = 3'd1;
    localparam logic [2:0] ACT_WRITE    = 3'd2;
    localparam logic [2:0] ACT_FLUSH    = 3'd3;
    localparam logic [2:0] ACT_REPLY    = 3'd4;
    localparam logic [2:0] ACT_ILLEGAL  = 3'd5;

    // reply kinds
    localparam logic [3:0] RK_NONE       = 4'd0;
    localparam logic [3:0] RK_INQUIRY    = 4'd1;
    localparam logic [3:0] RK_CONTROL    = 4'd2;
    localparam logic [3:0] RK_RECOVERY   = 4'd3;
    localparam logic [3:0] RK_CACHING    = 4'd4;
    localparam logic [3:0] RK_ALL_PAGES  = 4'd5;
    localparam logic [3:0] RK_CAPACITY10 = 4'd6;
    localparam logic [3:0] RK_CAPACITY16 = 4'd7;
    localparam logic [3:0] RK_LUNS_BASE  = 4'd8;

    // reply lengths in bytes
    localparam logic [5:0] LEN_INQUIRY    = 6'd36;
    localparam logic [5:0] LEN_CONTROL    = 6'd20;
    localparam logic [5:0] LEN_RECOVERY   = 6'd20;
    localparam logic [5:0] LEN_CACHING    = 6'd28;
    localparam logic [5:0] LEN_ALL_PAGES  = 6'd52;
    localparam logic [5:0] LEN_CAPACITY10 = 6'd8;
    localparam logic [5:0] LEN_CAPACITY16 = 6'd32;
    localparam logic [5:0] LEN_LUNS       = 6'd40;

    // mode pages
    localparam logic [5:0] PAGE_CONTROL  = 6'h0A;
    localparam logic [5:0] PAGE_RECOVERY = 6'h01;
    localparam logic [5:0] PAGE_CACHING  = 6'h08;
    localparam logic [5:0] PAGE_ALL      = 6'h3F;

    // well-known logical units and their inquiry index
    localparam logic [7:0] LUN_NORMAL      = 8'h00;
    localparam logic [7:0] LUN_REPORT_LUNS = 8'h81;
    localparam logic [7:0] LUN_DEVICE      = 8'hD0;
    localparam logic [7:0] LUN_BOOT        = 8'hB0;
    localparam logic [7:0] LUN_RPMB        = 8'hC4;

    localparam logic [2:0] UNIT_NORMAL      = 3'd0;
    localparam logic [2:0] UNIT_REPORT_LUNS = 3'd1;
    localparam logic [2:0] UNIT_DEVICE      = 3'd2;
    localparam logic [2:0] UNIT_BOOT        = 3'd3;
    localparam logic [2:0] UNIT_RPMB        = 3'd4;

    // report luns selects
    localparam logic [7:0] LUNS_SELECT_MAX = 8'd2;

    // register indexes
    localparam logic [1:0] REG_LBA_SIZE      = 2'd0;
    localparam logic [1:0] REG_LBAS_PER_PAGE = 2'd1;
    localparam logic [1:0] REG_TOTAL_PAGES   = 2'd2;

    // register reset values
    localparam logic [16:0] LBA_SIZE_RST      = 17'd4096;
    localparam logic [6:0]  LBAS_PER_PAGE_RST = 7'd4;
    localparam logic [39:0] TOTAL_PAGES_RST   = 40'd1048576;

    // one item as it travels down the pipeline
    typedef struct packed {
        logic [2:0]  action;
        logic [31:0] start_lba;
        logic [15:0] block_count;
        logic [3:0]  reply_kind;
        logic [5:0]  reply_length;
        logic [2:0]  unit_index;
        logic        flush_wait;
        logic        map_en;
        logic        verify_chk;
        logic        cap10;
        logic        cap16;
        logic [45:0] last_lba;
        logic [31:0] byte_length;
        logic [21:0] byte_offset;
        logic [31:0] quo;
        logic [6:0]  rem;
        logic [16:0] numer;
        logic [15:0] page_q;
    } item_t;

    // one restoring division step: returns {quotient bit, remainder}
    function automatic logic [7:0] div_bit(input logic [6:0] rem, input logic nb,
                                           input logic [6:0] d);
        logic [7:0] t;
        logic [7:0] diff;
        t    = {rem, nb};
        diff = t - {1'b0, d};
        if (t >= {1'b0, d})
            div_bit = {1'b1, diff[6:0]};
        else
            div_bit = {1'b0, t[6:0]};
    endfunction

    // eight division steps: returns {quotient byte, remainder}
    function automatic logic [14:0] div_byte(input logic [6:0] rem, input logic [7:0] nb,
                                             input logic [6:0] d);
        logic [6:0] r;
        logic [7:0] q;
        logic [7:0] s;
        r = rem;
        q = '0;
        for (int i = 7; i >= 0; i--)
        begin
            s    = div_bit(r, nb[i], d);
            q[i] = s[7];
            r    = s[6:0];
        end
        div_byte = {q, r};
    endfunction

endpackage

// ===== hdl/scsi_cdb_command_decoder.sv =====
// SCSI command block decoder. Takes one ten-byte command block and a LUN per
// item and returns one result item: the action, the decoded LBA range mapped
// onto internal pages, and the reply kind and length for answered commands.
// An item is taken in every cycle unless a stalled output backs up to the input;
// it passes through eight register stages, a depth set by the division by blocks
// per page, which runs eight quotient bits per stage (four stages for the start
// page, two more for the page count). A stalled output holds only the full
// stages behind it, so bubbles close up. Blocks per page of zero acts as one.
// The user must write registers only while no item is in flight; not enforced.
module scsi_cdb_command_decoder
    import scsi_cdb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [39:0] cfg_data,
    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] cdb_head,
    input  logic [15:0] cdb_tail,
    input  logic [7:0]  unit_number,
    // output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  action,
    output logic [31:0] start_lba,
    output logic [15:0] block_count,
    output logic [31:0] start_page,
    output logic [15:0] page_count,
    output logic [21:0] byte_offset,
    output logic [31:0] byte_length,
    output logic [3:0]  reply_kind,
    output logic [5:0]  reply_length,
    output logic [2:0]  unit_index,
    output logic [45:0] last_lba,
    output logic        flush_wait
);

    logic [16:0] lba_size_reg;
    logic [6:0]  lbas_per_page_reg;
    logic [39:0] total_pages_reg;
    logic [46:0] total_lbas_reg;
    logic [46:0] total_lbas_next;
    logic [6:0]  ratio;

    logic [8:1]  vld_reg;
    logic [8:1]  rdy;

    item_t dec;
    item_t s1_reg, s2_reg, s3_reg, s4_reg, s5_reg, s6_reg, s7_reg, s8_reg;
    item_t s2_next, s3_next, s4_next, s5_next, s6_next, s7_next, s8_next;

    logic [14:0] d2, d3, d4, d5, d7, d8;
    logic [7:0]  d7_top;
    logic [32:0] blen_full;
    logic [46:0] need_lbas;
    logic [46:0] last_full;
    logic [23:0] boff_full;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lba_size_reg      <= LBA_SIZE_RST;
            lbas_per_page_reg <= LBAS_PER_PAGE_RST;
            total_pages_reg   <= TOTAL_PAGES_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LBA_SIZE:      lba_size_reg      <= cfg_data[16:0];
                REG_LBAS_PER_PAGE: lbas_per_page_reg <= cfg_data[6:0];
                REG_TOTAL_PAGES:   total_pages_reg   <= cfg_data;
                default:           ;
            endcase
        end
    end

    // device size in blocks, follows the registers
    assign total_lbas_next = {7'd0, total_pages_reg} * {40'd0, lbas_per_page_reg};

    always_ff @(posedge clk)
    begin
        total_lbas_reg <= total_lbas_next;
    end

    assign ratio = (lbas_per_page_reg == 7'd0) ? 7'd1 : lbas_per_page_reg;

    // stage readiness, a stage moves when empty or when the next one moves
    always_comb
    begin
        rdy[8] = !vld_reg[8] || !out_stall;
        for (int k = 7; k >= 1; k--)
        begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    end

    assign in_stall = !rdy[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (rdy[1])
                vld_reg[1] <= in_valid;
            for (int k = 2; k <= 8; k++)
            begin
                if (rdy[k])
                    vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // stage 1: command decode
    scsi_cdb_decode u_decode (
        .cdb_head    (cdb_head),
        .cdb_tail    (cdb_tail),
        .unit_number (unit_number),
        .item        (dec)
    );

    // stage 2: byte length, verify range, capacity, start page bits 31..24
    always_comb
    begin
        s2_next   = s1_reg;
        blen_full = {17'd0, s1_reg.block_count} * {16'd0, lba_size_reg};
        need_lbas = {15'd0, s1_reg.start_lba} + {31'd0, s1_reg.block_count};
        last_full = total_lbas_reg - 47'd1;
        d2        = div_byte(7'd0, s1_reg.start_lba[31:24], ratio);

        s2_next.byte_length = blen_full[31:0];
        if (s1_reg.verify_chk && (need_lbas > total_lbas_reg))
            s2_next.action = ACT_ILLEGAL;
        if (s1_reg.cap10)
            s2_next.last_lba = {14'd0, last_full[31:0]};
        else if (s1_reg.cap16)
            s2_next.last_lba = last_full[45:0];
        else
            s2_next.last_lba = '0;
        s2_next.quo = {d2[14:7], 24'd0};
        s2_next.rem = d2[6:0];
    end

    // stages 3 to 5: remaining start page bits
    always_comb
    begin
        s3_next     = s2_reg;
        d3          = div_byte(s2_reg.rem, s2_reg.start_lba[23:16], ratio);
        s3_next.quo = {s2_reg.quo[31:24], d3[14:7], 16'd0};
        s3_next.rem = d3[6:0];
    end

    always_comb
    begin
        s4_next     = s3_reg;
        d4          = div_byte(s3_reg.rem, s3_reg.start_lba[15:8], ratio);
        s4_next.quo = {s3_reg.quo[31:16], d4[14:7], 8'd0};
        s4_next.rem = d4[6:0];
    end

    always_comb
    begin
        s5_next     = s4_reg;
        d5          = div_byte(s4_reg.rem, s4_reg.start_lba[7:0], ratio);
        s5_next.quo = {s4_reg.quo[31:8], d5[14:7]};
        s5_next.rem = d5[6:0];
    end

    // stage 6: byte offset and the rounded-up page numerator
    always_comb
    begin
        s6_next             = s5_reg;
        boff_full           = {17'd0, s5_reg.rem} * {7'd0, lba_size_reg};
        s6_next.byte_offset = boff_full[21:0];
        s6_next.numer       = {10'd0, s5_reg.rem} + {1'b0, s5_reg.block_count} +
                              {10'd0, ratio} - 17'd1;
    end

    // stage 7: page count bits 16..8, the top bit falls outside the field
    always_comb
    begin
        s7_next        = s6_reg;
        d7_top         = div_bit(7'd0, s6_reg.numer[16], ratio);
        d7             = div_byte(d7_top[6:0], s6_reg.numer[15:8], ratio);
        s7_next.page_q = {d7[14:7], 8'd0};
        s7_next.rem    = d7[6:0];
    end

    // stage 8: page count bits 7..0, mapping fields only for read and write
    always_comb
    begin
        s8_next        = s7_reg;
        d8             = div_byte(s7_reg.rem, s7_reg.numer[7:0], ratio);
        s8_next.page_q = {s7_reg.page_q[15:8], d8[14:7]};
        if (!s7_reg.map_en)
        begin
            s8_next.quo         = '0;
            s8_next.page_q      = '0;
            s8_next.byte_offset = '0;
            s8_next.byte_length = '0;
        end
    end

    // pipeline data registers
    always_ff @(posedge clk)
    begin
        if (rdy[1] && in_valid)
            s1_reg <= dec;
        if (rdy[2] && vld_reg[1])
            s2_reg <= s2_next;
        if (rdy[3] && vld_reg[2])
            s3_reg <= s3_next;
        if (rdy[4] && vld_reg[3])
            s4_reg <= s4_next;
        if (rdy[5] && vld_reg[4])
            s5_reg <= s5_next;
        if (rdy[6] && vld_reg[5])
            s6_reg <= s6_next;
        if (rdy[7] && vld_reg[6])
            s7_reg <= s7_next;
        if (rdy[8] && vld_reg[7])
            s8_reg <= s8_next;
    end

    // result item
    assign out_valid    = vld_reg[8];
    assign action       = s8_reg.action;
    assign start_lba    = s8_reg.start_lba;
    assign block_count  = s8_reg.block_count;
    assign start_page   = s8_reg.quo;
    assign page_count   = s8_reg.page_q;
    assign byte_offset  = s8_reg.byte_offset;
    assign byte_length  = s8_reg.byte_length;
    assign reply_kind   = s8_reg.reply_kind;
    assign reply_length = s8_reg.reply_length;
    assign unit_index   = s8_reg.unit_index;
    assign last_lba     = s8_reg.last_lba;
    assign flush_wait   = s8_reg.flush_wait;

endmodule

// ===== hdl/scsi_cdb_decode.sv =====
module scsi_cdb_decode
    import scsi_cdb_pkg::*;
(
    input  logic [63:0] cdb_head,
    input  logic [15:0] cdb_tail,
    input  logic [7:0]  unit_number,
    output item_t       item
);

    logic [7:0]  op;
    logic [7:0]  b1;
    logic [7:0]  b2;
    logic [7:0]  b3;
    logic [7:0]  b4;
    logic [7:0]  b5;
    logic [7:0]  b7;
    logic [7:0]  b8;
    logic [15:0] nlb;
    logic        is_read;

    // command bytes
    assign op = cdb_head[63:56];
    assign b1 = cdb_head[55:48];
    assign b2 = cdb_head[47:40];
    assign b3 = cdb_head[39:32];
    assign b4 = cdb_head[31:24];
    assign b5 = cdb_head[23:16];
    assign b7 = cdb_head[7:0];
    assign b8 = cdb_tail[15:8];

    assign is_read = (op == OP_READ_6) || (op == OP_READ_10);

    // opcode decode
    always_comb
    begin
        item = '0;
        nlb  = '0;
        unique case (op) inside
            OP_INQUIRY:
            begin
                unique case (unit_number)
                    LUN_NORMAL:      item.unit_index = UNIT_NORMAL;
                    LUN_REPORT_LUNS: item.unit_index = UNIT_REPORT_LUNS;
                    LUN_DEVICE:      item.unit_index = UNIT_DEVICE;
                    LUN_BOOT:        item.unit_index = UNIT_BOOT;
                    LUN_RPMB:        item.unit_index = UNIT_RPMB;
                    default:         item.unit_index = UNIT_NORMAL;
                endcase
                if (unit_number == LUN_NORMAL || unit_number == LUN_REPORT_LUNS ||
                    unit_number == LUN_DEVICE || unit_number == LUN_BOOT ||
                    unit_number == LUN_RPMB)
                begin
                    item.action       = ACT_REPLY;
                    item.reply_kind   = RK_INQUIRY;
                    item.reply_length = LEN_INQUIRY;
                end
            end
            OP_MODE_SENSE_10:
            begin
                unique case (b2[5:0])
                    PAGE_CONTROL:
                    begin
                        item.action       = ACT_REPLY;
                        item.reply_kind   = RK_CONTROL;
                        item.reply_length = LEN_CONTROL;
                    end
                    PAGE_RECOVERY:
                    begin
                        item.action       = ACT_REPLY;
                        item.reply_kind   = RK_RECOVERY;
                        item.reply_length = LEN_RECOVERY;
                    end
                    PAGE_CACHING:
                    begin
                        item.action       = ACT_REPLY;
                        item.reply_kind   = RK_CACHING;
                        item.reply_length = LEN_CACHING;
                    end
                    PAGE_ALL:
                    begin
                        item.action       = ACT_REPLY;
                        item.reply_kind   = RK_ALL_PAGES;
                        item.reply_length = LEN_ALL_PAGES;
                    end
                    default:
                    begin
                        item.action = ACT_COMPLETE;
                    end
                endcase
            end
            OP_READ_CAPACITY_10:
            begin
                item.action       = ACT_REPLY;
                item.reply_kind   = RK_CAPACITY10;
                item.reply_length = LEN_CAPACITY10;
                item.cap10        = 1'b1;
            end
            OP_READ_CAPACITY_16:
            begin
                item.action       = ACT_REPLY;
                item.reply_kind   = RK_CAPACITY16;
                item.reply_length = LEN_CAPACITY16;
                item.cap16        = 1'b1;
            end
            OP_REPORT_LUNS:
            begin
                item.action       = ACT_REPLY;
                item.reply_length = LEN_LUNS;
                if (b2 <= LUNS_SELECT_MAX)
                    item.reply_kind = RK_LUNS_BASE + b2[3:0];
            end
            OP_READ_6, OP_WRITE_6:
            begin
                nlb              = (b4 == 8'd0) ? 16'd256 : {8'd0, b4};
                item.start_lba   = {11'd0, b1[4:0], b2, b3};
                item.block_count = nlb;
                item.map_en      = (nlb != 16'd0);
                item.action      = is_read ? ACT_READ : ACT_WRITE;
            end
            OP_READ_10, OP_WRITE_10, OP_VERIFY_10, OP_SYNC_CACHE_10:
            begin
                nlb              = {b7, b8};
                item.start_lba   = {b2, b3, b4, b5};
                item.block_count = nlb;
                if (op == OP_VERIFY_10)
                begin
                    item.verify_chk = 1'b1;
                end
                else if (op == OP_SYNC_CACHE_10)
                begin
                    item.action     = ACT_FLUSH;
                    item.flush_wait = !b1[4];
                end
                else if (nlb != 16'd0)
                begin
                    item.map_en = 1'b1;
                    item.action = is_read ? ACT_READ : ACT_WRITE;
                end
            end
            default:
            begin
                item.action = ACT_COMPLETE;
            end
        endcase
    end

endmodule

// ===== hdl/scsi_cdb_checker.sv =====
module scsi_cdb_assertions
    import scsi_cdb_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        cfg_we,
    input logic [1:0]  cfg_index,
    input logic [39:0] cfg_data,
    input logic        in_valid,
    input logic        in_stall,
    input logic [63:0] cdb_head,
    input logic [15:0] cdb_tail,
    input logic [7:0]  unit_number,
    input logic        out_valid,
    input logic        out_stall,
    input logic [2:0]  action,
    input logic [31:0] start_lba,
    input logic [15:0] block_count,
    input logic [31:0] start_page,
    input logic [15:0] page_count,
    input logic [21:0] byte_offset,
    input logic [31:0] byte_length,
    input logic [3:0]  reply_kind,
    input logic [5:0]  reply_length,
    input logic [2:0]  unit_index,
    input logic [45:0] last_lba,
    input logic        flush_wait
);

    // a stalled result item stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result item dropped while stalled");

    // a stalled result item keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(action) && $stable(start_lba) &&
                                   $stable(start_page) && $stable(page_count))
        else $error("result item changed while stalled");

    // a data transfer always moves at least one block and one page
    a_xfer_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (action == ACT_READ || action == ACT_WRITE)
            |-> block_count != 16'd0 && page_count != 16'd0)
        else $error("transfer with no blocks");

    // page mapping is only given for read and write
    a_map_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && action != ACT_READ && action != ACT_WRITE
            |-> start_page == 32'd0 && page_count == 16'd0 &&
                byte_offset == 22'd0 && byte_length == 32'd0)
        else $error("page mapping on a non-transfer command");

    // reply data only comes with a reply action
    a_reply_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && reply_kind != RK_NONE |-> action == ACT_REPLY)
        else $error("reply kind without reply action");

endmodule

bind scsi_cdb_command_decoder scsi_cdb_assertions u_checker (.*);
